### sv/uartrx_pkg.sv
// Package for the 8N1 serial receiver with receive ring.
// Holds the frame phase type, register indexes and the request passed from front to back.
// No dependencies.
`default_nettype none

package uartrx_pkg;

    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int QDEPTH    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD         = 1'b1;

    // Frame phase: idle, eight data bits (the next sample is that bit), stop period.
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_BIT0 = 4'd1,
        PH_BIT1 = 4'd2,
        PH_BIT2 = 4'd3,
        PH_BIT3 = 4'd4,
        PH_BIT4 = 4'd5,
        PH_BIT5 = 4'd6,
        PH_BIT6 = 4'd7,
        PH_BIT7 = 4'd8,
        PH_STOP = 4'd9
    } phase_t;

    // One tick's work for the ring side.
    typedef struct packed {
        logic              pop;
        logic              push;
        logic [DATA_W-1:0] data;
        logic              frame_active;
    } uartrx_req_t;

endpackage

`default_nettype wire

### sv/uartrx_front.sv
// Front part of the receiver: configuration registers and the frame deserialiser.
// Turns each accepted tick into a ring request. Depends on uartrx_pkg.
`default_nettype none

module uartrx_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [uartrx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [uartrx_pkg::DATA_W-1:0]    cfg_wdata,
    input  wire logic                             accept,
    input  wire logic                             rx_line,
    input  wire logic                             pop_req,
    output uartrx_pkg::uartrx_req_t               req
);
    import uartrx_pkg::*;

    logic [DATA_W-1:0] first_delay_reg;
    logic [DATA_W-1:0] bit_period_reg;
    phase_t            phase_reg,     phase_next;
    logic [DATA_W-1:0] shifter_reg,   shifter_next;
    logic [DATA_W-1:0] countdown_reg, countdown_next;
    logic              prev_line_reg, prev_line_next;
    logic [DATA_W-1:0] countdown_dec;
    logic              push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg <= 8'd156;
            bit_period_reg  <= 8'd104;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FIRST_SAMPLE_DELAY)
            begin
                first_delay_reg <= cfg_wdata;
            end
            else if (cfg_index == CFG_BIT_PERIOD)
            begin
                bit_period_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shifter_reg   <= '0;
            countdown_reg <= '0;
            prev_line_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            shifter_reg   <= shifter_next;
            countdown_reg <= countdown_next;
            prev_line_reg <= prev_line_next;
        end
    end

    assign countdown_dec = countdown_reg - 8'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        shifter_next   = shifter_reg;
        countdown_next = countdown_reg;
        prev_line_next = rx_line;
        push           = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            // Only a fresh falling edge opens a frame.
            if (prev_line_reg && !rx_line)
            begin
                phase_next     = PH_BIT0;
                shifter_next   = '0;
                countdown_next = first_delay_reg;
            end
        end
        else if (countdown_dec == '0)
        begin
            countdown_next = bit_period_reg;
            if (phase_reg != PH_STOP)
            begin
                shifter_next = {rx_line, shifter_reg[DATA_W-1:1]};
                push         = (phase_reg == PH_BIT7);
                phase_next   = phase_t'(phase_reg + 4'd1);
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            countdown_next = countdown_dec;
        end
    end

    always_comb
    begin
        req.pop          = pop_req;
        req.push         = push;
        req.data         = shifter_next;
        req.frame_active = (phase_next != PH_IDLE);
    end

endmodule

`default_nettype wire

### sv/uartrx_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on uartrx_pkg for the request type.
`default_nettype none

module uartrx_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire uartrx_pkg::uartrx_req_t  push_data,
    output logic                          full,
    input  wire logic                     pop,
    output uartrx_pkg::uartrx_req_t       pop_data,
    output logic                          not_empty
);
    import uartrx_pkg::*;

    uartrx_req_t entry_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign full      = (count_reg == 2'(QDEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("request queue read while empty");

endmodule

`default_nettype wire

### sv/uartrx_back.sv
// Back part of the receiver: the receive ring and the result register.
// Serves the pop before the push of each request. Depends on uartrx_pkg.
`default_nettype none

module uartrx_back #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_avail,
    input  wire uartrx_pkg::uartrx_req_t       req,
    output logic                               take,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [uartrx_pkg::DATA_W-1:0]      popped_byte,
    output logic                               popped_valid,
    output logic                               ring_not_empty,
    output logic                               frame_active
);
    import uartrx_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_inc, wp_inc;
    logic              do_pop, do_push;
    logic              out_valid_reg;
    logic              popped_valid_reg;
    logic              not_empty_reg;
    logic              frame_active_reg;

    assign take = req_avail && (!out_valid_reg || !out_stall);

    always_comb
    begin
        rp_inc  = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);
        wp_inc  = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
        do_pop  = req.pop && (rp_reg != wp_reg);
        rp_next = do_pop ? rp_inc : rp_reg;
        // One slot stays empty; a byte that finds the ring full is dropped.
        do_push = req.push && (wp_inc != rp_next);
        wp_next = do_push ? wp_inc : wp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take && do_push)
        begin
            ring_mem[wp_reg] <= req.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && do_pop)
        begin
            rd_data_reg <= ring_mem[rp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg           <= '0;
            wp_reg           <= '0;
            out_valid_reg    <= 1'b0;
            popped_valid_reg <= 1'b0;
            not_empty_reg    <= 1'b0;
            frame_active_reg <= 1'b0;
        end
        else if (take)
        begin
            rp_reg           <= rp_next;
            wp_reg           <= wp_next;
            out_valid_reg    <= 1'b1;
            popped_valid_reg <= do_pop;
            not_empty_reg    <= (rp_next != wp_next);
            frame_active_reg <= req.frame_active;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign popped_valid   = popped_valid_reg;
    assign popped_byte    = popped_valid_reg ? rd_data_reg : '0;
    assign ring_not_empty = not_empty_reg;
    assign frame_active   = frame_active_reg;

    a_flag_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (not_empty_reg == (rp_reg != wp_reg)))
        else $error("ring_not_empty disagrees with the ring pointers");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req.pop && (rp_reg == wp_reg)) |=> !popped_valid_reg)
        else $error("pop served from an empty ring");

endmodule

`default_nettype wire

### sv/uart_receiver_with_fifo.sv
// Top level of the 8N1 serial receiver with receive ring.
// Instantiates uartrx_front, uartrx_queue and uartrx_back; depends on uartrx_pkg.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------------------
//   in        in_valid / in_stall  rx_line, pop_req (one line tick per request)
//   out       out_valid/out_stall  popped_byte, popped_valid, ring_not_empty, frame_active
//   cfg       cfg_we               cfg_index, cfg_wdata (0: first sample delay, 1: bit period)
//
// One tick request is taken every clock cycle while in_stall is low. It is written into
// the front-to-back queue; when the output can move, the back part takes it and loads the
// result registers and the ring read data together, which then drive the output.
// Reset (rst_n low) empties the ring, returns the deserialiser to idle and loads
// the default timing of 156 and 104 ticks; the ring storage itself is not cleared.
// A stall on the output holds the result register; the two-entry queue then fills
// and in_stall rises, so the line deserialiser never advances without a free slot.
`default_nettype none

module uart_receiver_with_fifo #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [uartrx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [uartrx_pkg::DATA_W-1:0]    cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             rx_line,
    input  wire logic                             pop_req,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [uartrx_pkg::DATA_W-1:0]         popped_byte,
    output logic                                  popped_valid,
    output logic                                  ring_not_empty,
    output logic                                  frame_active
);
    import uartrx_pkg::*;

    uartrx_req_t front_req;
    uartrx_req_t back_req;
    logic        accept;
    logic        q_full;
    logic        q_not_empty;
    logic        back_take;

    // The front only advances on requests that find room in the queue.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    uartrx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_line   (rx_line),
        .pop_req   (pop_req),
        .req       (front_req)
    );

    // Decouples the line timing from output back-pressure.
    uartrx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_req),
        .full      (q_full),
        .pop       (back_take),
        .pop_data  (back_req),
        .not_empty (q_not_empty)
    );

    // The back applies pop then push to the ring, in request order.
    uartrx_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_avail      (q_not_empty),
        .req            (back_req),
        .take           (back_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .popped_byte    (popped_byte),
        .popped_valid   (popped_valid),
        .ring_not_empty (ring_not_empty),
        .frame_active   (frame_active)
    );

endmodule

`default_nettype wire

### tb/tb_uart_receiver_with_fifo.sv
// Self-checking testbench for uart_receiver_with_fifo, the 8N1 receiver with a receive ring.
// A cycle-accurate line and ring predictor checks every tick result in order.
// Depends on uartrx_pkg and the uart_receiver_with_fifo RTL.
`timescale 1ns / 1ps

module tb_uart_receiver_with_fifo;

    import uartrx_pkg::*;

    localparam int RING_DEPTH          = 16;
    localparam int DEFAULT_FIRST_DELAY = 156;
    localparam int DEFAULT_BIT_PERIOD  = 104;
    localparam int MAX_REPORTS         = 10;
    localparam int RANDOM_TICKS        = 60;

    // Everything the block reports for one tick request.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              not_empty;
        logic              active;
    } tick_outcome_t;

    // Clock and reset. Reset is held low from time zero and released once.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs, all at known values from the start of the run.
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_SAMPLE_DELAY;
    logic [DATA_W-1:0]    cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 rx_line   = 1'b1;
    logic                 pop_req   = 1'b0;
    logic                 out_stall = 1'b0;

    // Block outputs.
    logic              in_stall;
    logic              out_valid;
    logic [DATA_W-1:0] popped_byte;
    logic              popped_valid;
    logic              ring_not_empty;
    logic              frame_active;

    // Predictor state: timing registers, deserialiser and ring.
    logic [7:0]        cfg_first_delay;
    logic [7:0]        cfg_bit_period;
    phase_t            rx_phase;
    logic [7:0]        rx_shift;
    logic [7:0]        rx_count;
    logic              rx_prev;
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    int                wr_ptr;
    int                rd_ptr;

    // Results still owed by the block, oldest first.
    tick_outcome_t pending_outcomes [$];

    // Idling controls, in percent per cycle.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Run statistics.
    int error_count   = 0;
    int tick_count    = 0;
    int result_count  = 0;
    int byte_count    = 0;
    int frame_count   = 0;
    int setting_count = 0;

    uart_receiver_with_fifo #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_line       (rx_line),
        .pop_req       (pop_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .popped_byte   (popped_byte),
        .popped_valid  (popped_valid),
        .ring_not_empty(ring_not_empty),
        .frame_active  (frame_active)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int ring_next(input int p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    task automatic reset_model();
        cfg_first_delay = 8'(DEFAULT_FIRST_DELAY);
        cfg_bit_period  = 8'(DEFAULT_BIT_PERIOD);
        rx_phase        = PH_IDLE;
        rx_shift        = '0;
        rx_count        = '0;
        rx_prev         = 1'b1;
        wr_ptr          = 0;
        rd_ptr          = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_mem[i] = '0;
        end
    endtask

    // Advances the predictor by one line tick and returns what the block should report.
    // The pop is served first, so a full ring can accept a byte on the tick it is popped.
    function automatic tick_outcome_t next_tick_outcome(input logic line, input logic pop);
        tick_outcome_t outcome;
        int            next_wr;
        outcome = '0;
        if (pop && rd_ptr != wr_ptr)
        begin
            outcome.data  = ring_mem[rd_ptr];
            outcome.valid = 1'b1;
            rd_ptr        = ring_next(rd_ptr);
        end
        if (rx_phase == PH_IDLE)
        begin
            // Only a fresh falling edge starts a frame.
            if (rx_prev && !line)
            begin
                rx_phase = PH_BIT0;
                rx_shift = '0;
                rx_count = cfg_first_delay;
            end
        end
        else
        begin
            // A register value of zero wraps round to 256 ticks here.
            rx_count = rx_count - 8'd1;
            if (rx_count == 8'd0)
            begin
                rx_count = cfg_bit_period;
                if (rx_phase != PH_STOP)
                begin
                    rx_shift = {line, rx_shift[7:1]};
                    if (rx_phase == PH_BIT7)
                    begin
                        next_wr = ring_next(wr_ptr);
                        if (next_wr != rd_ptr)
                        begin
                            ring_mem[wr_ptr] = rx_shift;
                            wr_ptr           = next_wr;
                        end
                    end
                    rx_phase = phase_t'(rx_phase + 4'd1);
                end
                else
                begin
                    rx_phase = PH_IDLE;
                end
            end
        end
        rx_prev           = line;
        outcome.not_empty = (rd_ptr != wr_ptr);
        outcome.active    = (rx_phase != PH_IDLE);
        return outcome;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // The receiver side stalls at random; one assignment per clock edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Every accepted result is compared field by field with the oldest expectation.
    // Outputs and out_stall are sampled as they stood before this edge, so there is
    // no dependence on the order of processes within the time step.
    always @(posedge clk)
    begin : check_outcome
        tick_outcome_t expected;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_error("result arrived with no tick request outstanding");
            end
            else
            begin
                expected = pending_outcomes.pop_front();
                if (popped_byte !== expected.data)
                begin
                    report_error($sformatf("result %0d popped_byte: expected %02h, got %02h",
                                           result_count, expected.data, popped_byte));
                end
                if (popped_valid !== expected.valid)
                begin
                    report_error($sformatf("result %0d popped_valid: expected %0b, got %0b",
                                           result_count, expected.valid, popped_valid));
                end
                if (ring_not_empty !== expected.not_empty)
                begin
                    report_error($sformatf("result %0d ring_not_empty: expected %0b, got %0b",
                                           result_count, expected.not_empty, ring_not_empty));
                end
                if (frame_active !== expected.active)
                begin
                    report_error($sformatf("result %0d frame_active: expected %0b, got %0b",
                                           result_count, expected.active, frame_active));
                end
                if (expected.valid)
                begin
                    byte_count++;
                end
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one tick request and holds it until the block takes it. The prediction
    // is made at the accepting edge. Afterwards the sender may go idle for a while;
    // each idle cycle is decided afresh so that gaps land on every phase of a frame.
    task automatic send_tick(input logic line, input logic pop);
        tick_outcome_t outcome;
        in_valid <= 1'b1;
        rx_line  <= line;
        pop_req  <= pop;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        outcome = next_tick_outcome(line, pop);
        pending_outcomes.push_back(outcome);
        tick_count++;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every outstanding request has produced its result,
    // then lets the pipeline settle for a few cycles.
    task automatic drain_outcomes();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Holds the line high until the predictor says the frame in progress has ended.
    task automatic finish_frame();
        while (rx_phase != PH_IDLE)
        begin
            send_tick(1'b1, 1'b0);
        end
    endtask

    // Pops until the ring is empty, then one more pop on the empty ring.
    task automatic empty_ring();
        while (rd_ptr != wr_ptr)
        begin
            send_tick(1'b1, 1'b1);
        end
        send_tick(1'b1, 1'b1);
    endtask

    // Writes both timing registers on consecutive edges. The block is first brought
    // to rest: no frame in progress and no request outstanding.
    task automatic set_timing(input logic [7:0] first_delay, input logic [7:0] period);
        finish_frame();
        drain_outcomes();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_SAMPLE_DELAY;
        cfg_wdata <= first_delay;
        @(posedge clk);
        cfg_index <= CFG_BIT_PERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_first_delay = first_delay;
        cfg_bit_period  = period;
        setting_count++;
        repeat (2) @(posedge clk);
    endtask

    // Sends one frame carrying data, LSB first. The line for each tick is the bit that
    // the next sample will take, read from the predicted phase, so any timing works.
    // glitch_pct replaces that many line levels in a hundred with random ones, stop_level
    // is the line during the stop period, and end_edge pulls the line low on the very
    // tick the frame ends, where the edge must be ignored.
    task automatic send_frame(input logic [7:0] data, input int pop_pct, input int glitch_pct,
                              input logic stop_level, input logic end_edge);
        logic line;
        finish_frame();
        if (!rx_prev)
        begin
            send_tick(1'b1, ($urandom_range(0, 99) < pop_pct));
        end
        send_tick(1'b0, ($urandom_range(0, 99) < pop_pct));
        while (rx_phase != PH_IDLE)
        begin
            if (rx_phase == PH_STOP)
            begin
                line = (end_edge && rx_count == 8'd1) ? 1'b0 : stop_level;
            end
            else
            begin
                line = data[int'(rx_phase) - 1];
            end
            if ($urandom_range(0, 99) < glitch_pct)
            begin
                line = 1'($urandom_range(0, 1));
            end
            send_tick(line, ($urandom_range(0, 99) < pop_pct));
        end
        frame_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: pop on the empty ring, then one frame at the default timing.
    task automatic test_reset_timing();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_tick(1'b1, 1'b1);
        send_frame(8'h5A, 0, 0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
    endtask

    // Delays of one tick, all-zero and all-one bytes, alternating bits (edges in the
    // middle of a frame), an edge on the closing tick, and a line left low at idle.
    task automatic test_short_timing_cases();
        set_timing(8'd1, 8'd1);
        send_frame(8'h00, 0, 0, 1'b1, 1'b0);
        send_frame(8'hFF, 0, 0, 1'b1, 1'b0);
        send_frame(8'hAA, 0, 0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_frame(8'h3C, 0, 0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_frame(8'hC3, 0, 0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_frame(8'h96, 50, 0, 1'b1, 1'b0);
        empty_ring();
    endtask

    // A first sample delay of zero, which wraps round to 256 ticks, with a bit period of one
    // tick, and then a timing of two ticks.
    task automatic test_timing_extremes();
        sender_idle_pct    = 18;
        receiver_stall_pct = 18;
        set_timing(8'd0, 8'd1);
        send_frame(8'h7E, 1, 0, 1'b1, 1'b0);
        set_timing(8'd2, 8'd2);
        send_frame(8'h42, 0, 0, 1'b1, 1'b0);
        empty_ring();
    endtask

    // Fills the ring past its capacity so the extra bytes are dropped, then drains it.
    task automatic test_ring_overflow();
        sender_idle_pct    = 18;
        receiver_stall_pct = 18;
        set_timing(8'd2, 8'd1);
        empty_ring();
        repeat (RING_DEPTH + 2)
        begin
            send_frame(8'($urandom_range(0, 255)), 0, 0, 1'b1, 1'b0);
        end
        send_frame(8'($urandom_range(0, 255)), 5, 0, 1'b1, 1'b0);
        empty_ring();
    endtask

    // Mostly well-formed frames with random bytes and random pops, mixed with corrupted
    // frames, line noise, pop bursts, occasional retiming and full drains of the pipeline.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int first_tick;
        int pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        set_timing(8'($urandom_range(2, 6)), 8'($urandom_range(2, 4)));
        first_tick = tick_count;
        while (tick_count - first_tick < RANDOM_TICKS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 64)
            begin
                send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 30), 0, 1'b1, 1'b0);
                repeat ($urandom_range(0, 3))
                begin
                    send_tick(1'b1, ($urandom_range(0, 99) < 20));
                end
            end
            else if (pick < 77)
            begin
                send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 50), 15,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 89)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 20))
                begin
                    send_tick(1'b1, 1'b1);
                end
            end
            else if (pick < 98)
            begin
                // The sender holds off, even mid-frame, until all results are back.
                drain_outcomes();
            end
            else
            begin
                set_timing(8'($urandom_range(2, 8)), 8'($urandom_range(2, 5)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_short_timing_cases();
        test_timing_extremes();
        test_ring_overflow();
        test_random_traffic(0, 0);
        test_random_traffic(73, 0);
        test_random_traffic(0, 73);
        test_random_traffic(18, 18);

        // Wait for the last results, then a few more cycles to catch any stray output.
        drain_outcomes();
        repeat (16) @(posedge clk);

        $display("Covered %0d line ticks in %0d frames over %0d timing settings; %0d bytes popped.",
                 tick_count, frame_count, setting_count, byte_count);
        $display("Idling mixes: none, sender only, receiver only, both; ring overfilled once.");
        if (error_count == 0 && pending_outcomes.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #24_000_000;
        $display("Timed out with %0d results outstanding.", pending_outcomes.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
